FILE: rtl/chmv_pkg.sv
// chmv_pkg: shared constants and types of the chained hash map with vector keys
// no dependencies; used by the channel interfaces and the top level

package chmv_pkg;

	localparam int unsigned ENTRIES_DEF       = 1024;
	localparam int unsigned BUCKETS_DEF       = 4096;
	localparam int unsigned MAX_KEY_WORDS_DEF = 20;

	// multiplier of the key hash
	localparam logic [31:0] HASH_MUL = 32'd1234567891;

	localparam int unsigned OPC_W = 2;
	localparam int unsigned KLEN_W = 5;
	localparam int unsigned WORD_W = 32;

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PAD,
		S_HEAD,
		S_ENT,
		S_ELEN,
		S_CMP,
		S_HIT,
		S_MISS,
		S_WRRD,
		S_WRWR,
		S_OUT
	} state_t;

endpackage

FILE: rtl/chmv_in_if.sv
// chmv_in_if: request channel of the hash map, one key word per beat
// depends on chmv_pkg for field widths

interface chmv_in_if;
	logic                                valid;
	logic                                ready;
	logic [chmv_pkg::OPC_W-1:0]          opcode;
	logic [chmv_pkg::KLEN_W-1:0]         key_length;
	logic signed [chmv_pkg::WORD_W-1:0]  key_word;
	logic                                last_word;
	logic signed [chmv_pkg::WORD_W-1:0]  value;

	modport source (output valid, opcode, key_length, key_word, last_word, value, input ready);
	modport sink (input valid, opcode, key_length, key_word, last_word, value, output ready);
endinterface

FILE: rtl/chmv_out_if.sv
// chmv_out_if: response channel of the hash map, one result per beat
// depends on chmv_pkg for field widths

interface chmv_out_if;
	logic                                valid;
	logic                                ready;
	logic                                found;
	logic signed [chmv_pkg::WORD_W-1:0]  value_out;
	logic                                pool_full;

	modport source (output valid, found, value_out, pool_full, input ready);
	modport sink (input valid, found, value_out, pool_full, output ready);
endinterface

FILE: rtl/chained_hash_map_vector_key_unit.sv
// chained_hash_map_vector_key_unit: chained hash map keyed by word vectors
// depends on chmv_pkg, chmv_in_if and chmv_out_if
//
//  channel  dir  beat                                          handshake
//  req      in   opcode, key_length, key_word, last_word, value  valid/ready
//  rsp      out  found, value_out, pool_full                    valid/ready
//
// a non-final key word is taken in S_IDLE; a final word then passes S_PAD, which pads
// each missing word with zero, S_HEAD to fetch the bucket head, S_ENT, S_ELEN and S_CMP
// for each chain entry visited, S_HIT or S_MISS to close the walk, S_OUT to hand over the
// result, and on a new insert S_WRRD and S_WRWR per key word to copy the staged key into
// the pool; after reset and after every clear the bucket heads are zeroed by a sweep
// during which req is not ready
// a finished result sits in the output register; req is taken again at once, and a
// following result waits in S_OUT until rsp has drained

module chained_hash_map_vector_key_unit #(
	parameter int unsigned ENTRIES       = chmv_pkg::ENTRIES_DEF,
	parameter int unsigned BUCKETS       = chmv_pkg::BUCKETS_DEF,
	parameter int unsigned MAX_KEY_WORDS = chmv_pkg::MAX_KEY_WORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	chmv_in_if.sink    req,
	chmv_out_if.source rsp
);

	localparam int unsigned W     = chmv_pkg::WORD_W;
	localparam int unsigned HB    = $clog2(BUCKETS);            // bucket index bits
	localparam int unsigned PW    = $clog2(ENTRIES + 1);        // pointer, 0 is end of chain
	localparam int unsigned EW    = $clog2(ENTRIES);            // pool index
	localparam int unsigned LW    = $clog2(MAX_KEY_WORDS + 1);  // key length
	localparam int unsigned SKW   = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
	localparam int unsigned WDEP  = ENTRIES * MAX_KEY_WORDS;
	localparam int unsigned WAW   = $clog2(WDEP);
	localparam int unsigned SDEP  = (MAX_KEY_WORDS > 1) ? MAX_KEY_WORDS : 2;
	localparam logic [HB-1:0] HMUL = HB'(chmv_pkg::HASH_MUL);

	// memories
	logic [PW-1:0] head_mem [BUCKETS];
	logic [PW-1:0] next_mem [ENTRIES];
	logic [LW-1:0] len_mem  [ENTRIES];
	logic [W-1:0]  val_mem  [ENTRIES];
	logic [W-1:0]  word_mem [WDEP];
	logic [W-1:0]  stg_mem  [SDEP];

	chmv_pkg::state_t state_q, state_d;

	logic [HB-1:0]  clr_idx_q;
	logic           key_open_q;
	logic [LW-1:0]  len_q, wc_q, i_q;
	logic [HB-1:0]  hash_q;
	logic [chmv_pkg::OPC_W-1:0] op_q;
	logic [W-1:0]   val_q, eval_q;
	logic [PW-1:0]  p_q, next_q, head_q, used_q;
	logic [WAW-1:0] base_q;
	logic           res_found_q, res_full_q;
	logic [W-1:0]   res_val_q;
	logic           out_valid_q, out_found_q, out_full_q;
	logic [W-1:0]   out_val_q;

	// read data, registered inside the memories
	logic [PW-1:0] head_rd, nxt_rd;
	logic [LW-1:0] len_rd;
	logic [W-1:0]  val_rd, word_rd, stg_rd;

	// front end: staging of one key word
	logic          acc;
	logic [LW-1:0] len_sat, len_eff, wc_eff;
	logic [HB-1:0] h_eff, h_acc;
	logic          take;

	// sequencer controls
	logic          head_we, stg_we, meta_we, val_we, word_we;
	logic [HB-1:0] head_waddr;
	logic [PW-1:0] head_wdata;
	logic [SKW-1:0] stg_waddr, stg_raddr;
	logic [W-1:0]  stg_wdata;
	logic [EW-1:0] meta_raddr, val_waddr;
	logic [LW-1:0] rd_i;
	logic [WAW-1:0] word_raddr, base_d;
	logic [EW-1:0] e_cur;
	logic          out_free;

	function automatic logic [HB-1:0] hstep(input logic [HB-1:0] h, input logic [W-1:0] w);
		logic [HB-1:0] m;
		m = h * HMUL;
		return m + w[HB-1:0];
	endfunction

	assign acc      = req.valid && req.ready;
	assign req.ready = (state_q == chmv_pkg::S_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	assign len_sat = (32'(req.key_length) > 32'(MAX_KEY_WORDS)) ? LW'(MAX_KEY_WORDS)
	                                                             : LW'(req.key_length);
	assign len_eff = key_open_q ? len_q : len_sat;
	assign wc_eff  = key_open_q ? wc_q : '0;
	assign h_eff   = key_open_q ? hash_q : HB'(len_sat);
	assign take    = (wc_eff < len_eff);
	assign h_acc   = take ? hstep(h_eff, req.key_word) : h_eff;

	assign e_cur  = EW'(p_q - PW'(1));
	assign base_d = (state_q == chmv_pkg::S_MISS) ? WAW'(used_q[EW-1:0]) * WAW'(MAX_KEY_WORDS)
	                                              : WAW'(e_cur) * WAW'(MAX_KEY_WORDS);

	// index of the key word fetched for the next compare or copy
	always_comb begin
		unique case (state_q)
			chmv_pkg::S_ELEN: rd_i = '0;
			chmv_pkg::S_CMP:  rd_i = i_q + LW'(1);
			default:          rd_i = i_q;
		endcase
	end
	assign word_raddr = base_q + WAW'(rd_i);
	assign stg_raddr  = SKW'(rd_i);
	assign meta_raddr = e_cur;

	// memory write controls
	always_comb begin
		head_we    = 1'b0;
		head_waddr = hash_q;
		head_wdata = used_q + PW'(1);
		stg_we     = 1'b0;
		stg_waddr  = SKW'(wc_q);
		stg_wdata  = '0;
		meta_we    = 1'b0;
		val_we     = 1'b0;
		val_waddr  = used_q[EW-1:0];
		word_we    = 1'b0;
		unique case (state_q)
			chmv_pkg::S_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_idx_q;
				head_wdata = '0;
			end
			chmv_pkg::S_IDLE: begin
				stg_we    = acc && (req.opcode == chmv_pkg::OP_INSERT ||
				                    req.opcode == chmv_pkg::OP_LOOKUP) && take;
				stg_waddr = SKW'(wc_eff);
				stg_wdata = req.key_word;
			end
			chmv_pkg::S_PAD: begin
				stg_we = (wc_q < len_q);
			end
			chmv_pkg::S_HIT: begin
				val_we    = (op_q == chmv_pkg::OP_INSERT);
				val_waddr = e_cur;
			end
			chmv_pkg::S_MISS: begin
				if (op_q == chmv_pkg::OP_INSERT && used_q != PW'(ENTRIES)) begin
					head_we = 1'b1;
					meta_we = 1'b1;
					val_we  = 1'b1;
				end
			end
			chmv_pkg::S_WRWR: word_we = 1'b1;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chmv_pkg::S_CLEAR:
				if (clr_idx_q == HB'(BUCKETS - 1)) state_d = chmv_pkg::S_IDLE;
			chmv_pkg::S_IDLE: begin
				if (acc) begin
					if (req.opcode == chmv_pkg::OP_CLEAR) state_d = chmv_pkg::S_CLEAR;
					else if (req.opcode != chmv_pkg::OP_NONE && req.last_word)
						state_d = chmv_pkg::S_PAD;
				end
			end
			chmv_pkg::S_PAD:
				if (wc_q >= len_q) state_d = chmv_pkg::S_HEAD;
			chmv_pkg::S_HEAD: state_d = chmv_pkg::S_ENT;
			chmv_pkg::S_ENT:
				state_d = (p_q == '0) ? chmv_pkg::S_MISS : chmv_pkg::S_ELEN;
			chmv_pkg::S_ELEN: begin
				if (len_rd != len_q) state_d = chmv_pkg::S_ENT;
				else if (len_q == '0) state_d = chmv_pkg::S_HIT;
				else state_d = chmv_pkg::S_CMP;
			end
			chmv_pkg::S_CMP: begin
				if (word_rd != stg_rd) state_d = chmv_pkg::S_ENT;
				else if (i_q + LW'(1) == len_q) state_d = chmv_pkg::S_HIT;
			end
			chmv_pkg::S_HIT: state_d = chmv_pkg::S_OUT;
			chmv_pkg::S_MISS: begin
				if (op_q == chmv_pkg::OP_INSERT && used_q != PW'(ENTRIES) && len_q != '0)
					state_d = chmv_pkg::S_WRRD;
				else state_d = chmv_pkg::S_OUT;
			end
			chmv_pkg::S_WRRD: state_d = chmv_pkg::S_WRWR;
			chmv_pkg::S_WRWR:
				state_d = (i_q + LW'(1) == len_q) ? chmv_pkg::S_OUT : chmv_pkg::S_WRRD;
			chmv_pkg::S_OUT:
				if (out_free) state_d = chmv_pkg::S_IDLE;
			default: state_d = chmv_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= chmv_pkg::S_CLEAR;
		else state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			key_open_q <= 1'b0;
			len_q      <= '0;
			wc_q       <= '0;
			hash_q     <= '0;
			used_q     <= '0;
			i_q        <= '0;
			p_q        <= '0;
			op_q       <= '0;
		end else begin
			unique case (state_q)
				chmv_pkg::S_CLEAR: clr_idx_q <= clr_idx_q + HB'(1);
				chmv_pkg::S_IDLE: begin
					if (acc && req.opcode == chmv_pkg::OP_CLEAR) begin
						used_q     <= '0;
						key_open_q <= 1'b0;
						wc_q       <= '0;
						hash_q     <= '0;
						clr_idx_q  <= '0;
					end else if (acc && req.opcode != chmv_pkg::OP_NONE) begin
						len_q      <= len_eff;
						wc_q       <= take ? wc_eff + LW'(1) : wc_eff;
						hash_q     <= h_acc;
						key_open_q <= !req.last_word;
						op_q       <= req.opcode;
					end
				end
				chmv_pkg::S_PAD: begin
					// missing words count as zero
					if (wc_q < len_q) begin
						wc_q   <= wc_q + LW'(1);
						hash_q <= hstep(hash_q, '0);
					end
				end
				chmv_pkg::S_HEAD: p_q <= head_rd;
				chmv_pkg::S_ENT:  i_q <= '0;
				chmv_pkg::S_ELEN: if (len_rd != len_q) p_q <= nxt_rd;
				chmv_pkg::S_CMP: begin
					if (word_rd != stg_rd) p_q <= next_q;
					else i_q <= i_q + LW'(1);
				end
				chmv_pkg::S_MISS: begin
					i_q <= '0;
					if (op_q == chmv_pkg::OP_INSERT && used_q != PW'(ENTRIES))
						used_q <= used_q + PW'(1);
				end
				chmv_pkg::S_WRWR: i_q <= i_q + LW'(1);
				default: ;
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (acc && req.last_word) val_q <= req.value;
		if (state_q == chmv_pkg::S_HEAD) head_q <= head_rd;
		if (state_q == chmv_pkg::S_ENT || state_q == chmv_pkg::S_MISS) base_q <= base_d;
		if (state_q == chmv_pkg::S_ELEN) begin
			next_q <= nxt_rd;
			eval_q <= val_rd;
		end
		if (state_q == chmv_pkg::S_HIT) begin
			res_found_q <= 1'b1;
			res_full_q  <= 1'b0;
			res_val_q   <= (op_q == chmv_pkg::OP_LOOKUP) ? eval_q : '0;
		end
		if (state_q == chmv_pkg::S_MISS) begin
			res_found_q <= 1'b0;
			res_val_q   <= '0;
			res_full_q  <= (op_q == chmv_pkg::OP_INSERT) && (used_q == PW'(ENTRIES));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == chmv_pkg::S_OUT && out_free) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == chmv_pkg::S_OUT && out_free) begin
			out_found_q <= res_found_q;
			out_val_q   <= res_val_q;
			out_full_q  <= res_full_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.found     = out_found_q;
	assign rsp.value_out = out_val_q;
	assign rsp.pool_full = out_full_q;

	// memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_waddr] <= head_wdata;
		head_rd <= head_mem[hash_q];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			next_mem[used_q[EW-1:0]] <= head_q;
			len_mem[used_q[EW-1:0]]  <= len_q;
		end
		nxt_rd <= next_mem[meta_raddr];
		len_rd <= len_mem[meta_raddr];
	end

	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_waddr] <= val_q;
		val_rd <= val_mem[meta_raddr];
	end

	always_ff @(posedge clk) begin
		if (word_we) word_mem[base_q + WAW'(i_q)] <= stg_rd;
		word_rd <= word_mem[word_raddr];
	end

	always_ff @(posedge clk) begin
		if (stg_we) stg_mem[stg_waddr] <= stg_wdata;
		stg_rd <= stg_mem[stg_raddr];
	end

`ifndef SYNTHESIS
	// the pool never grows past its size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= PW'(ENTRIES))
		else $error("pool fill count beyond pool size");

	// a staged key never holds more words than its length
	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_open_q |-> (wc_q <= len_q))
		else $error("word count beyond key length");

	// a new result only comes from the result state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == chmv_pkg::S_OUT))
		else $error("result raised outside result state");

	// a clear op always starts a head sweep
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.opcode == chmv_pkg::OP_CLEAR) |=>
		(state_q == chmv_pkg::S_CLEAR && clr_idx_q == '0))
		else $error("clear did not start sweep");
`endif

endmodule

FILE: tb/chained_hash_map_vector_key_unit_tb.sv
// chained_hash_map_vector_key_unit_tb: self-checking bench for the vector-key hash map
// depends on chmv_pkg, chmv_in_if, chmv_out_if and the top level of the unit
// a scoreboard class predicts every response from the accepted request beats
`timescale 1ns / 100ps

module chained_hash_map_vector_key_unit_tb;

	localparam int unsigned NENT  = chmv_pkg::ENTRIES_DEF;
	localparam int unsigned NBKT  = chmv_pkg::BUCKETS_DEF;
	localparam int unsigned MAXW  = chmv_pkg::MAX_KEY_WORDS_DEF;
	localparam int IDLE_LIMIT     = 40000;
	localparam int FILL_KEYS      = NENT + 8;

	// predicted map state and the queue of responses still owed by the unit
	class hash_map_scoreboard;
		int unsigned head[NBKT];
		int unsigned nxt[NENT];
		int unsigned elen[NENT];
		bit [31:0]   ekey[NENT][MAXW];
		bit [31:0]   evalue[NENT];
		int unsigned used;
		bit [31:0]   stage[MAXW];
		int unsigned hsh, cnt, slen;
		bit          open;
		bit          found_q[$];
		bit [31:0]   value_q[$];
		bit          full_q[$];

		function void reset_state();
			foreach (head[i]) head[i] = 0;
			used = 0; hsh = 0; cnt = 0; slen = 0; open = 0;
		endfunction

		function void mix(bit [31:0] w);
			bit [31:0] t;
			t = hsh * chmv_pkg::HASH_MUL + w;
			hsh = t & (NBKT - 1);
		endfunction

		function bit key_equal(int unsigned e);
			if (elen[e] != slen) return 0;
			for (int i = 0; i < slen; i++)
				if (ekey[e][i] != stage[i]) return 0;
			return 1;
		endfunction

		function int unsigned chain_search(int unsigned b);
			int unsigned p, steps;
			p = head[b];
			steps = 0;
			while (p != 0 && steps < NENT) begin
				if (p - 1 >= used) return 0;
				if (key_equal(p - 1)) return p;
				p = nxt[p - 1];
				steps++;
			end
			return 0;
		endfunction

		function void note_input(bit [1:0] op, bit [4:0] len, bit [31:0] w, bit last,
				bit [31:0] v);
			int unsigned b, hit, l;
			bit [31:0] vo;
			bit full;
			if (chmv_pkg::opcode_t'(op) == chmv_pkg::OP_NONE) return;
			if (chmv_pkg::opcode_t'(op) == chmv_pkg::OP_CLEAR) begin
				foreach (head[i]) head[i] = 0;
				used = 0; open = 0; cnt = 0; hsh = 0;
				return;
			end
			if (!open) begin
				l = (len > MAXW) ? MAXW : len;
				slen = l; hsh = l & (NBKT - 1); cnt = 0; open = 1;
			end
			if (cnt < slen) begin
				stage[cnt] = w; mix(w); cnt++;
			end
			if (!last) return;
			// missing words count as zero
			while (cnt < slen) begin
				stage[cnt] = 0; mix(0); cnt++;
			end
			b = hsh; open = 0; cnt = 0; hsh = 0;
			hit = chain_search(b);
			vo = 0; full = 0;
			if (chmv_pkg::opcode_t'(op) == chmv_pkg::OP_INSERT) begin
				if (hit != 0) evalue[hit - 1] = v;
				else if (used >= NENT) full = 1;
				else begin
					nxt[used] = head[b];
					elen[used] = slen;
					for (int k = 0; k < MAXW; k++) ekey[used][k] = (k < slen) ? stage[k] : 0;
					evalue[used] = v;
					used++;
					head[b] = used;
				end
			end else if (hit != 0) vo = evalue[hit - 1];
			found_q.push_back(hit != 0);
			value_q.push_back(vo);
			full_q.push_back(full);
		endfunction

		function string check(bit f, bit [31:0] vo, bit pf);
			bit ef, epf;
			bit [31:0] evo;
			if (found_q.size() == 0) return "response with nothing outstanding";
			ef = found_q.pop_front(); evo = value_q.pop_front(); epf = full_q.pop_front();
			if (f !== ef || vo !== evo || pf !== epf)
				return $sformatf("got found=%0b value=%h full=%0b, want %0b %h %0b",
					f, vo, pf, ef, evo, epf);
			return "";
		endfunction

		function int pending();
			return found_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	chmv_in_if  req();
	chmv_out_if rsp();

	chained_hash_map_vector_key_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	hash_map_scoreboard sb;
	int errors;
	int n_in, n_out;
	bit hold_req;      // asks the response side for one long hold-off
	bit steady;        // no sender gaps while set

	// remembered keys, reused so lookups and updates actually hit
	int unsigned kl[16];
	bit [31:0]   kw[16][32];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report(string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// one request beat; valid stays high across back-to-back beats
	task automatic send_beat(bit [1:0] op, bit [4:0] len, bit [31:0] w, bit last,
			bit [31:0] v);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) gap = 0;
		else if (r < 92) gap = $urandom_range(1, 3);
		else gap = $urandom_range(5, 40);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.opcode     <= op;
		req.key_length <= len;
		req.key_word   <= w;
		req.last_word  <= last;
		req.value      <= v;
		do @(posedge clk); while (!req.ready);
		sb.note_input(op, len, w, last, v);
		n_in++;
	endtask

	// a key as nbeats beats; only the first length field and the last opcode count
	task automatic send_key(chmv_pkg::opcode_t op, bit [4:0] len, bit [31:0] w[32],
			int nbeats, bit [31:0] v, bit noisy);
		bit [1:0] mop;
		for (int i = 0; i < nbeats; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_beat(chmv_pkg::OP_NONE, 5'($urandom), $urandom, 1'($urandom),
					$urandom);
			mop = (i == nbeats - 1) ? op :
				($urandom_range(0, 1) ? chmv_pkg::OP_LOOKUP : chmv_pkg::OP_INSERT);
			send_beat(mop, (i == 0) ? len : 5'($urandom), w[i], i == nbeats - 1,
				(i == nbeats - 1) ? v : $urandom);
		end
	endtask

	function automatic bit [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// response side: random stall and run lengths, plus one long hold-off on request
	initial begin : rsp_ready_gen
		int stall_left, run_left, r;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				stall_left = 2500;
				run_left = 0;
			end
			if (stall_left == 0 && run_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 50) stall_left = 0;
				else if (r < 92) stall_left = $urandom_range(1, 4);
				else stall_left = $urandom_range(20, 80);
				run_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 30);
			end
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				run_left--;
			end
		end
	end

	// response checker
	always @(posedge clk) begin : rsp_check
		string m;
		if (rsp.valid && rsp.ready) begin
			m = sb.check(rsp.found, rsp.value_out, rsp.pool_full);
			if (m != "") report(m);
			n_out++;
		end
	end

	// watchdog on cycles with no beat on either channel
	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
			else idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", idle);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		bit [31:0] w[32];
		bit [31:0] base;
		int s, nb, r;
		bit [4:0] len;
		chmv_pkg::opcode_t op;
		sb = new();
		sb.reset_state();
		errors = 0; n_in = 0; n_out = 0; hold_req = 0; steady = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0; req.opcode = chmv_pkg::OP_NONE; req.key_length = '0;
		req.key_word = '0; req.last_word = 1'b0; req.value = '0;
		rsp.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty key, longest key, updates, saturation, padding, surplus, clear
		foreach (w[i]) w[i] = 0;
		send_key(chmv_pkg::OP_LOOKUP, 0, w, 1, 0, 0);
		send_key(chmv_pkg::OP_INSERT, 0, w, 1, 32'h7fff_ffff, 0);
		send_key(chmv_pkg::OP_LOOKUP, 0, w, 1, 0, 0);
		foreach (w[i]) w[i] = i[0] ? 32'hffff_ffff : 32'h8000_0000;
		send_key(chmv_pkg::OP_INSERT, 20, w, 20, 32'h8000_0000, 0);
		send_key(chmv_pkg::OP_LOOKUP, 20, w, 20, 0, 0);
		send_key(chmv_pkg::OP_INSERT, 20, w, 20, 32'h1234_5678, 0);
		send_key(chmv_pkg::OP_LOOKUP, 31, w, 20, 0, 0);       // oversize length saturates
		send_key(chmv_pkg::OP_INSERT, 31, w, 24, 32'hffff_ffff, 0); // surplus words dropped
		send_key(chmv_pkg::OP_LOOKUP, 20, w, 20, 0, 0);
		w[0] = 32'hdead_beef; w[1] = 0; w[2] = 0;
		send_key(chmv_pkg::OP_INSERT, 3, w, 1, 32'h0000_0001, 0);   // two words padded
		send_key(chmv_pkg::OP_LOOKUP, 3, w, 3, 0, 0);
		send_beat(chmv_pkg::OP_LOOKUP, 2, 32'h5555_5555, 0, 0);
		send_beat(chmv_pkg::OP_NONE, 31, 32'hffff_ffff, 1, 32'hffff_ffff); // staging kept
		send_beat(chmv_pkg::OP_LOOKUP, 0, 32'haaaa_aaaa, 1, 0);
		send_beat(chmv_pkg::OP_INSERT, 4, 32'h1111_1111, 0, 0);
		send_beat(chmv_pkg::OP_CLEAR, 0, 0, 0, 0);              // clear drops the half key
		send_key(chmv_pkg::OP_LOOKUP, 3, w, 3, 0, 0);
		send_key(chmv_pkg::OP_LOOKUP, 0, w, 1, 0, 0);

		// random keys from a small remembered set, with broken and noisy sequences
		for (int k = 0; k < 16; k++) begin
			kl[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 31) : $urandom_range(0, 4);
			for (int i = 0; i < 32; i++) kw[k][i] = pick_word();
		end
		for (int n = 0; n < 60; n++) begin
			if (n == 20) hold_req = 1;
			steady = (n >= 35 && n < 45);
			s = $urandom_range(0, 15);
			if ($urandom_range(0, 3) == 0) begin
				kl[s] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
				for (int i = 0; i < 32; i++) kw[s][i] = pick_word();
			end
			len = 5'(kl[s]);
			for (int i = 0; i < 32; i++) w[i] = kw[s][i];
			nb = (len > MAXW) ? MAXW : len;
			if (nb == 0) nb = 1;
			r = $urandom_range(0, 99);
			if (r < 8) nb = $urandom_range(1, nb);
			else if (r < 14) nb = nb + $urandom_range(1, 3);
			op = ($urandom_range(0, 99) < 45) ? chmv_pkg::OP_INSERT : chmv_pkg::OP_LOOKUP;
			if (n == 25 || n == 50)
				send_beat(chmv_pkg::OP_CLEAR, 5'($urandom), $urandom, 1'($urandom),
					$urandom);
			send_key(op, len, w, nb, $urandom, 1);
		end

		// fill the pool to the brim and beyond with short distinct keys
		steady = 0;
		send_beat(chmv_pkg::OP_CLEAR, 0, 0, 1, 0);
		base = $urandom;
		for (int n = 0; n < FILL_KEYS; n++) begin
			w[0] = base + n;
			send_key(chmv_pkg::OP_INSERT, 1, w, 1, $urandom, 0);
		end
		for (int n = 0; n < 40; n++) begin
			w[0] = base + $urandom_range(0, FILL_KEYS + 20);
			send_key(($urandom_range(0, 1) ? chmv_pkg::OP_INSERT : chmv_pkg::OP_LOOKUP),
				1, w, 1, $urandom, 0);
		end
		send_key(chmv_pkg::OP_LOOKUP, 0, w, 1, 0, 0);
		req.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.pending() != 0) report("responses still outstanding at the end");
		$display("ran %0d request beats and %0d responses: extremes, padding, clears,",
			n_in, n_out);
		$display("noise beats, a long response hold-off and inserts past a full pool");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
